// ===== hdl/gfa_pkg.sv =====
package gfa_pkg;

    localparam int GRID_ROWS  = 16;
    localparam int GRID_COLS  = 16;
    localparam int OWNER_BITS = 8;

    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int COL_W  = $clog2(GRID_COLS);
    localparam int CELL_W = ROW_W + COL_W;
    localparam int CELLS  = 2 ** CELL_W;
    localparam int SIZE_W = 5;
    localparam int SUM_W  = SIZE_W + 1;
    localparam int MASK_W = 2 ** SIZE_W;
    localparam int UPC_W  = 4;

    typedef logic [1:0]       cmd_t;
    typedef logic [3:0]       cond_t;
    typedef logic [UPC_W-1:0] upc_t;

    localparam cmd_t CMD_FIND   = 2'd0;
    localparam cmd_t CMD_PLACE  = 2'd1;
    localparam cmd_t CMD_REMOVE = 2'd2;
    localparam cmd_t CMD_QUERY  = 2'd3;

    localparam logic REG_ROWS_IN_USE = 1'b0;
    localparam logic REG_COLS_IN_USE = 1'b1;

    // jump conditions of the micro-program
    localparam cond_t C_ALWAYS    = 4'd0;
    localparam cond_t C_NO_ACCEPT = 4'd1;
    localparam cond_t C_IS_QUERY  = 4'd2;
    localparam cond_t C_IS_FIND   = 4'd3;
    localparam cond_t C_OUT_RANGE = 4'd4;
    localparam cond_t C_RECT_MORE = 4'd5;
    localparam cond_t C_FIND_BAD  = 4'd6;
    localparam cond_t C_SCAN_MORE = 4'd7;
    localparam cond_t C_OUT_BUSY  = 4'd8;

    // input word, last field lowest
    typedef struct packed {
        logic [3:0]        pad;
        logic [7:0]        owner;
        logic [SIZE_W-1:0] span_cols;
        logic [SIZE_W-1:0] span_rows;
        logic [3:0]        start_col;
        logic [3:0]        start_row;
        cmd_t              cmd;
    } in_word_t;

    // result word, last field lowest
    typedef struct packed {
        logic [5:0] pad;
        logic [7:0] cell_owner;
        logic       cell_occupied;
        logic [3:0] found_col;
        logic [3:0] found_row;
        logic       ok;
    } out_word_t;

    typedef struct packed {
        logic  accept_en;
        logic  clr_scan;
        logic  wr_cell;
        logic  scan_step;
        logic  q_rd;
        logic  set_ok;
        logic  out_load;
        cond_t cond;
        upc_t  target;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic is_query;
        logic is_find;
        logic out_range;
        logic rect_more;
        logic find_bad;
        logic scan_more;
        logic out_busy;
    } status_t;

endpackage

// ===== hdl/grid_rectangle_first_fit_allocator.sv =====
// channel   | ports                         | word contents
// ----------+-------------------------------+----------------------------------------------
// command   | s_tvalid s_tready s_tdata[31:0] | cmd, start_row, start_col, span_rows,
//           |                               | span_cols, owner
// result    | m_tvalid m_tready m_tdata[23:0] | ok, found_row, found_col, cell_occupied,
//           |                               | cell_owner
// config    | cfg_wr_en cfg_index cfg_wdata | 0 rows_in_use, 1 cols_in_use
//
// one command at a time under a micro-programmed sequencer; the result sits in an
// output register so the next command is taken while it waits
// from the taken word: a query reads its cell; place/remove checks the range, then
// writes one rectangle cell per step; find checks its arguments, then scans the rows
// in use of each column until a corner fits or the columns run out; then back to idle
// occupancy flops are cleared by reset at once; owner tags need no clearing pass
// a stalled result holds the sequencer in its final step until the word is taken
module grid_rectangle_first_fit_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[1:0] start_row[5:2] start_col[9:6] span_rows[14:10] span_cols[19:15] owner[27:20]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ok[0] found_row[4:1] found_col[8:5] cell_occupied[9] cell_owner[17:10]
    output logic [23:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_wdata
);
    import gfa_pkg::*;

    ctrl_t   cw;
    status_t st;

    // micro-program counter and control store
    gfa_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .cw      (cw)
    );

    // grid, counters, owner tags and result register
    gfa_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cw        (cw),
        .st        (st),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

`ifndef SYNTHESIS
    // a command is never followed by another in the next cycle
    a_single_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("command taken while previous one in progress");

    // an owner is only reported for an occupied cell
    a_owner_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[17:10] != 8'd0)) |-> m_tdata[9])
        else $error("owner reported for free cell");

    // occupancy is only reported by a query, which always answers ok
    a_occ_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[9]) |-> m_tdata[0])
        else $error("occupied cell without ok");

    // a corner other than the origin comes only from a successful find
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[8:1] != 8'd0)) |-> m_tdata[0])
        else $error("corner reported without ok");
`endif

endmodule

// ===== hdl/gfa_useq.sv =====
module gfa_useq (
    input  logic             aclk,
    input  logic             aresetn,
    input  gfa_pkg::status_t st,
    output gfa_pkg::ctrl_t   cw
);
    import gfa_pkg::*;

    localparam upc_t U_FIN   = 4'd0;
    localparam upc_t U_IDLE  = 4'd1;
    localparam upc_t U_DISPQ = 4'd2;
    localparam upc_t U_DISPF = 4'd3;
    localparam upc_t U_P0    = 4'd4;
    localparam upc_t U_P1    = 4'd5;
    localparam upc_t U_P2    = 4'd6;
    localparam upc_t U_F0    = 4'd7;
    localparam upc_t U_F1    = 4'd8;
    localparam upc_t U_F2    = 4'd9;
    localparam upc_t U_Q0    = 4'd10;

    upc_t upc_reg;
    logic taken;

    function automatic ctrl_t ucode(input upc_t a);
        ctrl_t w;
        w = '0;
        unique case (a)
            U_FIN: begin
                w.out_load = 1'b1;
                w.cond = C_OUT_BUSY;  w.target = U_FIN;
            end
            U_IDLE: begin
                w.accept_en = 1'b1;
                w.cond = C_NO_ACCEPT; w.target = U_IDLE;
            end
            U_DISPQ: begin
                w.cond = C_IS_QUERY;  w.target = U_Q0;
            end
            U_DISPF: begin
                w.cond = C_IS_FIND;   w.target = U_F0;
            end
            U_P0: begin
                w.cond = C_OUT_RANGE; w.target = U_FIN;
            end
            U_P1: begin
                w.wr_cell = 1'b1;
                w.set_ok = 1'b1;
                w.cond = C_RECT_MORE; w.target = U_P1;
            end
            U_P2: begin
                w.cond = C_ALWAYS;    w.target = U_FIN;
            end
            U_F0: begin
                w.clr_scan = 1'b1;
                w.cond = C_FIND_BAD;  w.target = U_FIN;
            end
            U_F1: begin
                w.scan_step = 1'b1;
                w.cond = C_SCAN_MORE; w.target = U_F1;
            end
            U_F2: begin
                w.cond = C_ALWAYS;    w.target = U_FIN;
            end
            U_Q0: begin
                w.q_rd = 1'b1;
                w.set_ok = 1'b1;
                w.cond = C_ALWAYS;    w.target = U_FIN;
            end
            default: begin
                w.cond = C_ALWAYS;    w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

    assign cw = ucode(upc_reg);

    always_comb begin
        unique case (cw.cond)
            C_ALWAYS:    taken = 1'b1;
            C_NO_ACCEPT: taken = !st.accept;
            C_IS_QUERY:  taken = st.is_query;
            C_IS_FIND:   taken = st.is_find;
            C_OUT_RANGE: taken = st.out_range;
            C_RECT_MORE: taken = st.rect_more;
            C_FIND_BAD:  taken = st.find_bad;
            C_SCAN_MORE: taken = st.scan_more;
            C_OUT_BUSY:  taken = st.out_busy;
            default:     taken = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= U_IDLE;
        end else begin
            upc_reg <= taken ? cw.target : upc_t'(upc_reg + 1'b1);
        end
    end

endmodule

// ===== hdl/gfa_datapath.sv =====
module gfa_datapath (
    input  logic             aclk,
    input  logic             aresetn,
    input  gfa_pkg::ctrl_t   cw,
    output gfa_pkg::status_t st,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [4:0]       cfg_wdata
);
    import gfa_pkg::*;

    in_word_t in_w;

    logic [SIZE_W-1:0] rows_cfg_reg, cols_cfg_reg;
    logic [SIZE_W-1:0] nr, nc;

    cmd_t              cmd_reg;
    logic [ROW_W-1:0]  srow_reg;
    logic [COL_W-1:0]  scol_reg;
    logic [SIZE_W-1:0] span_r_reg, span_c_reg;
    logic [OWNER_BITS-1:0] owner_reg;

    logic [ROW_W-1:0]  i_reg;
    logic [COL_W-1:0]  j_reg;
    logic [SIZE_W-1:0] run_reg;
    logic              ok_reg, qocc_reg;
    logic [3:0]        frow_reg, fcol_reg;

    logic [GRID_COLS-1:0]  occ_rows_reg [GRID_ROWS];
    logic [OWNER_BITS-1:0] owner_mem [CELLS];
    logic [OWNER_BITS-1:0] rd_data_reg;
    logic [CELL_W-1:0]     cell_addr;

    logic              m_tvalid_reg;
    out_word_t         m_word_reg;

    logic                 accept, out_busy;
    logic [GRID_COLS-1:0] row_word, cmask;
    logic [MASK_W-1:0]    wide_mask;
    logic                 seg_free, hit, row_last, col_end_next;
    logic [SIZE_W-1:0]    run_inc;
    logic [SUM_W-1:0]     row_end, col_end;
    logic                 in_range, q_in_range, last_cell;

    assign in_w     = in_word_t'(s_tdata);
    assign s_tready = cw.accept_en;
    assign accept   = s_tvalid && cw.accept_en;
    assign out_busy = m_tvalid_reg && !m_tready;

    assign nr = (rows_cfg_reg > SIZE_W'(GRID_ROWS)) ? SIZE_W'(GRID_ROWS) : rows_cfg_reg;
    assign nc = (cols_cfg_reg > SIZE_W'(GRID_COLS)) ? SIZE_W'(GRID_COLS) : cols_cfg_reg;

    // column segment of the current row under the rectangle
    assign row_word  = occ_rows_reg[i_reg];
    assign wide_mask = ((MASK_W'(1) << span_c_reg) - MASK_W'(1)) << j_reg;
    assign cmask     = wide_mask[GRID_COLS-1:0];
    assign seg_free  = (row_word & cmask) == '0;

    // free-row run per column gives the first fitting corner in column order, top row first
    assign run_inc      = run_reg + SIZE_W'(1);
    assign hit          = seg_free && (run_inc >= span_r_reg);
    assign row_last     = SIZE_W'(i_reg) == (nr - SIZE_W'(1));
    assign col_end_next = (SUM_W'(j_reg) + SUM_W'(1) + SUM_W'(span_c_reg)) > SUM_W'(nc);

    assign in_range = (span_r_reg != '0) && (span_c_reg != '0)
                   && (SUM_W'(srow_reg) + SUM_W'(span_r_reg) <= SUM_W'(nr))
                   && (SUM_W'(scol_reg) + SUM_W'(span_c_reg) <= SUM_W'(nc));
    assign row_end   = SUM_W'(srow_reg) + SUM_W'(span_r_reg) - SUM_W'(1);
    assign col_end   = SUM_W'(scol_reg) + SUM_W'(span_c_reg) - SUM_W'(1);
    assign last_cell = (SUM_W'(i_reg) == row_end) && (SUM_W'(j_reg) == col_end);

    assign q_in_range = (SIZE_W'(srow_reg) < nr) && (SIZE_W'(scol_reg) < nc);

    assign cell_addr = {i_reg, j_reg};

    always_comb begin
        st.accept    = accept;
        st.is_query  = cmd_reg == CMD_QUERY;
        st.is_find   = cmd_reg == CMD_FIND;
        st.out_range = !in_range;
        st.rect_more = !last_cell;
        st.find_bad  = (span_r_reg == '0) || (span_c_reg == '0) || (nr == '0)
                    || (span_c_reg > nc);
        st.scan_more = !hit && !(row_last && col_end_next);
        st.out_busy  = out_busy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_cfg_reg <= SIZE_W'(GRID_ROWS);
            cols_cfg_reg <= SIZE_W'(GRID_COLS);
            m_tvalid_reg <= 1'b0;
            for (int r = 0; r < GRID_ROWS; r++) begin
                occ_rows_reg[r] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_ROWS_IN_USE: rows_cfg_reg <= cfg_wdata;
                    REG_COLS_IN_USE: cols_cfg_reg <= cfg_wdata;
                endcase
            end
            if (cw.wr_cell) begin
                occ_rows_reg[i_reg][j_reg] <= (cmd_reg != CMD_REMOVE);
            end
            if (cw.out_load && !out_busy) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= in_w.cmd;
            srow_reg   <= ROW_W'(in_w.start_row);
            scol_reg   <= COL_W'(in_w.start_col);
            span_r_reg <= in_w.span_rows;
            span_c_reg <= in_w.span_cols;
            owner_reg  <= OWNER_BITS'(in_w.owner);
            i_reg      <= ROW_W'(in_w.start_row);
            j_reg      <= COL_W'(in_w.start_col);
            run_reg    <= '0;
            ok_reg     <= 1'b0;
            qocc_reg   <= 1'b0;
            frow_reg   <= '0;
            fcol_reg   <= '0;
        end
        if (cw.clr_scan) begin
            i_reg   <= '0;
            j_reg   <= '0;
            run_reg <= '0;
        end
        if (cw.wr_cell) begin
            if (SUM_W'(j_reg) == col_end) begin
                j_reg <= scol_reg;
                i_reg <= ROW_W'(i_reg + 1'b1);
            end else begin
                j_reg <= COL_W'(j_reg + 1'b1);
            end
        end
        if (cw.scan_step) begin
            if (hit) begin
                ok_reg   <= 1'b1;
                frow_reg <= 4'(SUM_W'(i_reg) + SUM_W'(1) - SUM_W'(span_r_reg));
                fcol_reg <= 4'(j_reg);
            end else if (row_last) begin
                i_reg   <= '0;
                j_reg   <= COL_W'(j_reg + 1'b1);
                run_reg <= '0;
            end else begin
                i_reg   <= ROW_W'(i_reg + 1'b1);
                run_reg <= seg_free ? run_inc : '0;
            end
        end
        if (cw.q_rd) begin
            qocc_reg <= q_in_range && row_word[j_reg];
        end
        if (cw.set_ok) begin
            ok_reg <= 1'b1;
        end
        if (cw.out_load && !out_busy) begin
            m_word_reg.pad           <= '0;
            m_word_reg.ok            <= ok_reg;
            m_word_reg.found_row     <= frow_reg;
            m_word_reg.found_col     <= fcol_reg;
            m_word_reg.cell_occupied <= qocc_reg;
            m_word_reg.cell_owner    <= qocc_reg ? 8'(rd_data_reg) : 8'd0;
        end
    end

    // owner tags: one write, one registered read
    always_ff @(posedge aclk) begin
        if (cw.wr_cell && (cmd_reg == CMD_PLACE)) begin
            owner_mem[cell_addr] <= owner_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= owner_mem[cell_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_word_reg;

endmodule
